// ===== design/dbc_pkg.sv =====
// Shared types and constants for the Base32 Damm check stream.
// Holds the word formats, the mode codes and the alphabet lookup.
// Used by every module in the design folder.
package dbc_pkg;

    localparam int DIGIT_W = 5;
    localparam int CODE_W  = 8;
    localparam int CHAR_W  = 7;

    // Low five bits of the field polynomial 0x23; the top bit is implied.
    localparam logic [DIGIT_W-1:0] FIELD_POLY_LOW = 5'h03;

    localparam logic MODE_COMPUTE = 1'b0;
    localparam logic MODE_VERIFY  = 1'b1;

    localparam logic [CODE_W-1:0] CODE_HYPHEN = 8'h2D;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              last_char;
    } char_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] check_char;
        logic              check_ok;
        logic              bad_char;
    } result_word_t;

    // Decoded form of one character.
    typedef struct packed {
        logic               hyphen;
        logic               in_alphabet;
        logic [DIGIT_W-1:0] digit;
    } digit_info_t;

    // Multiply by two in GF(2^5) with polynomial 0x23.
    function automatic logic [DIGIT_W-1:0] times_two(input logic [DIGIT_W-1:0] v);
        logic [DIGIT_W-1:0] t;
        t = {v[DIGIT_W-2:0], 1'b0};
        if (v[DIGIT_W-1])
        begin
            t = t ^ FIELD_POLY_LOW;
        end
        return t;
    endfunction

    // Map a digit back to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            5'd0:    c = 7'h30;
            5'd1:    c = 7'h31;
            5'd2:    c = 7'h32;
            5'd3:    c = 7'h33;
            5'd4:    c = 7'h34;
            5'd5:    c = 7'h35;
            5'd6:    c = 7'h36;
            5'd7:    c = 7'h37;
            5'd8:    c = 7'h38;
            5'd9:    c = 7'h39;
            5'd10:   c = 7'h41; // A
            5'd11:   c = 7'h42; // B
            5'd12:   c = 7'h43; // C
            5'd13:   c = 7'h44; // D
            5'd14:   c = 7'h45; // E
            5'd15:   c = 7'h46; // F
            5'd16:   c = 7'h47; // G
            5'd17:   c = 7'h48; // H
            5'd18:   c = 7'h4A; // J
            5'd19:   c = 7'h4B; // K
            5'd20:   c = 7'h4D; // M
            5'd21:   c = 7'h4E; // N
            5'd22:   c = 7'h50; // P
            5'd23:   c = 7'h51; // Q
            5'd24:   c = 7'h52; // R
            5'd25:   c = 7'h53; // S
            5'd26:   c = 7'h54; // T
            5'd27:   c = 7'h56; // V
            5'd28:   c = 7'h57; // W
            5'd29:   c = 7'h58; // X
            5'd30:   c = 7'h59; // Y
            default: c = 7'h5A; // Z
        endcase
        return c;
    endfunction

endpackage

// ===== design/dbc_decode.sv =====
// Character decoder: folds case and maps ASCII onto the Crockford Base32 digits.
// Depends on dbc_pkg.
module dbc_decode
    import dbc_pkg::*;
(
    input  logic [CODE_W-1:0] char_code,
    output digit_info_t       info
);

    logic [CODE_W-1:0] upper_code;

    always_comb
    begin
        upper_code = char_code;
        if (char_code >= 8'h61 && char_code <= 8'h7A)
        begin
            upper_code = char_code - 8'h20;
        end
    end

    always_comb
    begin
        info.hyphen      = (char_code == CODE_HYPHEN);
        info.in_alphabet = 1'b1;
        info.digit       = '0;
        case (upper_code)
            8'h30: info.digit = 5'd0;
            8'h31: info.digit = 5'd1;
            8'h32: info.digit = 5'd2;
            8'h33: info.digit = 5'd3;
            8'h34: info.digit = 5'd4;
            8'h35: info.digit = 5'd5;
            8'h36: info.digit = 5'd6;
            8'h37: info.digit = 5'd7;
            8'h38: info.digit = 5'd8;
            8'h39: info.digit = 5'd9;
            8'h41: info.digit = 5'd10;
            8'h42: info.digit = 5'd11;
            8'h43: info.digit = 5'd12;
            8'h44: info.digit = 5'd13;
            8'h45: info.digit = 5'd14;
            8'h46: info.digit = 5'd15;
            8'h47: info.digit = 5'd16;
            8'h48: info.digit = 5'd17;
            8'h4A: info.digit = 5'd18;
            8'h4B: info.digit = 5'd19;
            8'h4D: info.digit = 5'd20;
            8'h4E: info.digit = 5'd21;
            8'h50: info.digit = 5'd22;
            8'h51: info.digit = 5'd23;
            8'h52: info.digit = 5'd24;
            8'h53: info.digit = 5'd25;
            8'h54: info.digit = 5'd26;
            8'h56: info.digit = 5'd27;
            8'h57: info.digit = 5'd28;
            8'h58: info.digit = 5'd29;
            8'h59: info.digit = 5'd30;
            8'h5A: info.digit = 5'd31;
            default: info.in_alphabet = 1'b0;
        endcase
    end

endmodule

// ===== design/dbc_accum.sv =====
// Running Damm digit and sticky bad flag, plus formation of the result word.
// Depends on dbc_pkg; fed by dbc_decode.
module dbc_accum
    import dbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         last_char,
    input  digit_info_t  info,
    input  logic         check_mode,
    output result_word_t result
);

    logic [DIGIT_W-1:0] running_reg;
    logic [DIGIT_W-1:0] running_next;
    logic               bad_reg;
    logic               bad_next;
    logic [DIGIT_W-1:0] running_upd;
    logic               bad_upd;

    // A hyphen leaves the state alone; a bad character only sets the flag.
    always_comb
    begin
        running_upd = running_reg;
        bad_upd     = bad_reg;
        if (!info.hyphen)
        begin
            if (info.in_alphabet)
            begin
                running_upd = times_two(running_reg ^ info.digit);
            end
            else
            begin
                bad_upd = 1'b1;
            end
        end
    end

    always_comb
    begin
        result.bad_char   = bad_upd;
        result.check_char = '0;
        result.check_ok   = 1'b0;
        if (check_mode == MODE_COMPUTE)
        begin
            if (!bad_upd)
            begin
                result.check_char = digit_to_char(running_upd);
            end
        end
        else
        begin
            result.check_ok = (running_upd == '0) && !bad_upd;
        end
    end

    always_comb
    begin
        running_next = running_reg;
        bad_next     = bad_reg;
        if (step)
        begin
            if (last_char)
            begin
                running_next = '0;
                bad_next     = 1'b0;
            end
            else
            begin
                running_next = running_upd;
                bad_next     = bad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

// ===== design/damm_base32_check_stream.sv =====
// Top level of the Base32 Damm check stream: input register, decode and
// accumulate logic, result register and the mode register.
// Depends on dbc_pkg, dbc_decode and dbc_accum.
//
//   Channel   Signals                              Carries
//   char      char_valid / char_stall / char_word  one ASCII character and last mark
//   res       res_valid / res_stall / res_word     check character, pass flag, bad flag
//   cfg       cfg_valid / cfg_ready / cfg_data     check_mode (0 compute, 1 verify)
//
// One character is taken every cycle while char_stall is low; a result is valid
// once its last character has passed the input register and loaded the result register.
// Reset clears the running digit, the bad flag, the mode and all valid flags.
// Only a last character waits on a held result; other characters keep flowing.
// cfg_ready is always high; the mode is written whenever cfg_valid is high.
module damm_base32_check_stream
    import dbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  char_word_t   char_word,
    output logic         res_valid,
    input  logic         res_stall,
    output result_word_t res_word,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    logic         in_valid_reg;
    logic         in_valid_next;
    char_word_t   in_word_reg;
    logic         res_valid_reg;
    logic         res_valid_next;
    result_word_t res_word_reg;
    logic         mode_reg;
    logic         step;
    logic         accept;
    digit_info_t  info;
    result_word_t result;

    dbc_decode u_decode (
        .char_code (in_word_reg.char_code),
        .info      (info)
    );

    dbc_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .last_char  (in_word_reg.last_char),
        .info       (info),
        .check_mode (mode_reg),
        .result     (result)
    );

    // The held word moves on unless it needs the result slot and the slot is blocked.
    assign step = in_valid_reg
                  && (!in_word_reg.last_char || !res_valid_reg || !res_stall);
    assign char_stall = in_valid_reg && !step;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (step && in_word_reg.last_char)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mode_reg      <= MODE_COMPUTE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= char_word;
        end
        if (step && in_word_reg.last_char)
        begin
            res_word_reg <= result;
        end
    end

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
